@@ hw/rtl/bss_pkg.sv @@
package bss_pkg;

  localparam int NUM_WORDS  = 32;
  localparam int SPAN_WORDS = (NUM_WORDS < 32) ? NUM_WORDS : 32;
  localparam int SPAN_BITS  = SPAN_WORDS * 32;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = 5;
  localparam int POS_W      = 10;
  localparam int WIDX_W     = POS_W - BIT_W;
  localparam int LEN_W      = 11;
  localparam int RUN_W      = LEN_W + 1;
  localparam int CNT_W      = 11;
  localparam int ACT_W      = 4;
  localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET_BIT   = 4'd0,
    ACT_CLR_BIT   = 4'd1,
    ACT_SET_RUN   = 4'd2,
    ACT_CLR_RUN   = 4'd3,
    ACT_FIRST     = 4'd4,
    ACT_NEXT      = 4'd5,
    ACT_LAST      = 4'd6,
    ACT_COUNT     = 4'd7,
    ACT_CLEAR_ALL = 4'd8
  } action_t;

  typedef struct packed {
    logic             valid;
    logic [ACT_W-1:0] action;
    logic [POS_W-1:0] index;
    logic [LEN_W-1:0] run_length;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
    logic             clipped;
  } res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
    res_t res;
  } stat_t;

  // bits lo..hi of one word
  function automatic logic [WORD_W-1:0] range_mask(logic [BIT_W-1:0] lo,
                                                   logic [BIT_W-1:0] hi);
    logic [WORD_W-1:0] ones;
    ones = '1;
    return (ones << lo) & (ones >> (BIT_W'(WORD_W - 1) - hi));
  endfunction

  function automatic logic [BIT_W-1:0] lowest_set(logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [BIT_W-1:0] highest_set(logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [BIT_W:0] word_pop(logic [WORD_W-1:0] v);
    logic [BIT_W:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + (BIT_W + 1)'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/bss_ram.sv @@
module bss_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/bss_ctrl.sv @@
module bss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  bss_pkg::req_t req,
  input  logic          res_take,
  output bss_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    OP_SET,
    OP_CLR,
    OP_FIND_UP,
    OP_FIND_DOWN,
    OP_COUNT
  } op_t;

  state_t                          state_r, state_nxt;
  op_t                             op_r, op_nxt;
  logic                            iss_more_r, iss_more_nxt;
  logic                            rd_pend_r, rd_pend_nxt;
  logic                            dir_down_r, dir_down_nxt;
  logic [bss_pkg::WIDX_W-1:0]      iss_word_r, iss_word_nxt;
  logic [bss_pkg::WIDX_W-1:0]      rd_word_r, rd_word_nxt;
  logic [bss_pkg::WIDX_W-1:0]      first_word_r, first_word_nxt;
  logic [bss_pkg::WIDX_W-1:0]      last_word_r, last_word_nxt;
  logic [bss_pkg::BIT_W-1:0]       first_lo_r, first_lo_nxt;
  logic [bss_pkg::BIT_W-1:0]       last_hi_r, last_hi_nxt;
  logic                            found_r, found_nxt;
  logic [bss_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [bss_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic                            clipped_r, clipped_nxt;
  logic [bss_pkg::NUM_WORDS-1:0]   valid_r, valid_nxt;

  logic                            accept;
  logic [bss_pkg::RUN_W-1:0]       run_end;
  logic [bss_pkg::RUN_W-1:0]       run_endc;
  logic [bss_pkg::RUN_W-1:0]       run_lastp;
  logic [bss_pkg::LEN_W-1:0]       next_pos;
  logic                            run_over;

  logic                            wr_en;
  logic [bss_pkg::WORD_W-1:0]      wr_data;
  logic [bss_pkg::WORD_W-1:0]      rd_data;
  logic [bss_pkg::WORD_W-1:0]      word_q;
  logic [bss_pkg::WORD_W-1:0]      mask;
  logic [bss_pkg::WORD_W-1:0]      hitw;
  logic                            hit;
  logic                            finish;

  bss_ram #(
    .WIDTH (bss_pkg::WORD_W),
    .DEPTH (bss_pkg::NUM_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (bss_pkg::WADDR_W'(rd_word_r)),
    .wr_data (wr_data),
    .rd_en   (state_r == ST_SCAN && iss_more_r),
    .rd_addr (bss_pkg::WADDR_W'(iss_word_r)),
    .rd_data (rd_data)
  );

  assign accept    = (state_r == ST_IDLE) && req.valid;
  assign run_end   = bss_pkg::RUN_W'(req.index) + bss_pkg::RUN_W'(req.run_length);
  assign run_over  = run_end > bss_pkg::RUN_W'(bss_pkg::SPAN_BITS);
  assign run_endc  = run_over ? bss_pkg::RUN_W'(bss_pkg::SPAN_BITS) : run_end;
  assign run_lastp = run_endc - bss_pkg::RUN_W'(1);
  assign next_pos  = bss_pkg::LEN_W'(req.index) + bss_pkg::LEN_W'(1);

  // word arriving from the memory, words never written read as zero
  assign word_q = valid_r[bss_pkg::WADDR_W'(rd_word_r)] ? rd_data : '0;
  assign mask   = bss_pkg::range_mask(
                    (rd_word_r == first_word_r) ? first_lo_r : '0,
                    (rd_word_r == last_word_r) ? last_hi_r : '1);
  assign hitw   = word_q & mask;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    iss_more_nxt   = iss_more_r;
    rd_pend_nxt    = rd_pend_r;
    dir_down_nxt   = dir_down_r;
    iss_word_nxt   = iss_word_r;
    rd_word_nxt    = rd_word_r;
    first_word_nxt = first_word_r;
    last_word_nxt  = last_word_r;
    first_lo_nxt   = first_lo_r;
    last_hi_nxt    = last_hi_r;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    clipped_nxt    = clipped_r;
    valid_nxt      = valid_r;
    wr_en          = 1'b0;
    wr_data        = word_q;
    hit            = 1'b0;
    finish         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          found_nxt    = 1'b0;
          pos_nxt      = '0;
          count_nxt    = '0;
          clipped_nxt  = 1'b0;
          iss_more_nxt = 1'b1;
          rd_pend_nxt  = 1'b0;
          dir_down_nxt = 1'b0;
          first_lo_nxt = '0;
          last_hi_nxt  = '1;
          state_nxt    = ST_DONE;
          unique case (bss_pkg::action_t'(req.action))
            bss_pkg::ACT_SET_BIT, bss_pkg::ACT_CLR_BIT: begin
              op_nxt         = (req.action == bss_pkg::ACT_SET_BIT) ? OP_SET : OP_CLR;
              first_word_nxt = req.index[bss_pkg::POS_W-1:bss_pkg::BIT_W];
              last_word_nxt  = req.index[bss_pkg::POS_W-1:bss_pkg::BIT_W];
              first_lo_nxt   = req.index[bss_pkg::BIT_W-1:0];
              last_hi_nxt    = req.index[bss_pkg::BIT_W-1:0];
              if (bss_pkg::RUN_W'(req.index) < bss_pkg::RUN_W'(bss_pkg::SPAN_BITS)) begin
                state_nxt = ST_SCAN;
              end
            end
            bss_pkg::ACT_SET_RUN, bss_pkg::ACT_CLR_RUN: begin
              op_nxt         = (req.action == bss_pkg::ACT_SET_RUN) ? OP_SET : OP_CLR;
              first_word_nxt = req.index[bss_pkg::POS_W-1:bss_pkg::BIT_W];
              first_lo_nxt   = req.index[bss_pkg::BIT_W-1:0];
              last_word_nxt  = run_lastp[bss_pkg::POS_W-1:bss_pkg::BIT_W];
              last_hi_nxt    = run_lastp[bss_pkg::BIT_W-1:0];
              if (req.run_length != '0) begin
                clipped_nxt = run_over;
                if (bss_pkg::RUN_W'(req.index) < bss_pkg::RUN_W'(bss_pkg::SPAN_BITS)) begin
                  state_nxt = ST_SCAN;
                end
              end
            end
            bss_pkg::ACT_FIRST: begin
              op_nxt         = OP_FIND_UP;
              first_word_nxt = '0;
              last_word_nxt  = bss_pkg::WIDX_W'(bss_pkg::SPAN_WORDS - 1);
              state_nxt      = ST_SCAN;
            end
            bss_pkg::ACT_NEXT: begin
              op_nxt         = OP_FIND_UP;
              first_word_nxt = next_pos[bss_pkg::POS_W-1:bss_pkg::BIT_W];
              first_lo_nxt   = next_pos[bss_pkg::BIT_W-1:0];
              last_word_nxt  = bss_pkg::WIDX_W'(bss_pkg::SPAN_WORDS - 1);
              if (bss_pkg::RUN_W'(next_pos) < bss_pkg::RUN_W'(bss_pkg::SPAN_BITS)) begin
                state_nxt = ST_SCAN;
              end
            end
            bss_pkg::ACT_LAST: begin
              op_nxt         = OP_FIND_DOWN;
              dir_down_nxt   = 1'b1;
              first_word_nxt = bss_pkg::WIDX_W'(bss_pkg::SPAN_WORDS - 1);
              last_word_nxt  = '0;
              state_nxt      = ST_SCAN;
            end
            bss_pkg::ACT_COUNT: begin
              op_nxt         = OP_COUNT;
              first_word_nxt = '0;
              last_word_nxt  = bss_pkg::WIDX_W'(bss_pkg::SPAN_WORDS - 1);
              state_nxt      = ST_SCAN;
            end
            bss_pkg::ACT_CLEAR_ALL: begin
              valid_nxt = '0;
            end
            default: begin
            end
          endcase
          iss_word_nxt = first_word_nxt;
        end
      end

      ST_SCAN: begin
        // issue side: one word read per cycle
        if (iss_more_r) begin
          iss_word_nxt = dir_down_r ? iss_word_r - bss_pkg::WIDX_W'(1)
                                    : iss_word_r + bss_pkg::WIDX_W'(1);
          rd_word_nxt  = iss_word_r;
          iss_more_nxt = (iss_word_r != last_word_r);
        end
        // return side: modify and write back, or inspect
        if (rd_pend_r) begin
          unique case (op_r)
            OP_SET: begin
              wr_en   = 1'b1;
              wr_data = word_q | mask;
            end
            OP_CLR: begin
              wr_en   = 1'b1;
              wr_data = word_q & ~mask;
            end
            OP_FIND_UP: begin
              if (hitw != '0) begin
                hit       = 1'b1;
                found_nxt = 1'b1;
                pos_nxt   = {rd_word_r, bss_pkg::lowest_set(hitw)};
              end
            end
            OP_FIND_DOWN: begin
              if (hitw != '0) begin
                hit       = 1'b1;
                found_nxt = 1'b1;
                pos_nxt   = {rd_word_r, bss_pkg::highest_set(hitw)};
              end
            end
            OP_COUNT: begin
              count_nxt = count_r + bss_pkg::CNT_W'(bss_pkg::word_pop(word_q));
            end
            default: begin
            end
          endcase
          if (wr_en) begin
            valid_nxt[bss_pkg::WADDR_W'(rd_word_r)] = 1'b1;
          end
          finish = hit || (rd_word_r == last_word_r);
        end
        rd_pend_nxt = iss_more_r && !finish;
        if (finish) begin
          iss_more_nxt = 1'b0;
          state_nxt    = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      iss_more_r <= 1'b0;
      rd_pend_r  <= 1'b0;
      valid_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      iss_more_r <= iss_more_nxt;
      rd_pend_r  <= rd_pend_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    dir_down_r   <= dir_down_nxt;
    iss_word_r   <= iss_word_nxt;
    rd_word_r    <= rd_word_nxt;
    first_word_r <= first_word_nxt;
    last_word_r  <= last_word_nxt;
    first_lo_r   <= first_lo_nxt;
    last_hi_r    <= last_hi_nxt;
    found_r      <= found_nxt;
    pos_r        <= pos_nxt;
    count_r      <= count_nxt;
    clipped_r    <= clipped_nxt;
  end

  assign stat.idle         = (state_r == ST_IDLE);
  assign stat.res_valid    = (state_r == ST_DONE);
  assign stat.res.found    = found_r;
  assign stat.res.position = pos_r;
  assign stat.res.count    = count_r;
  assign stat.res.clipped  = clipped_r;

endmodule

@@ hw/rtl/bitmap_set_scan.sv @@
// Bitmap of 32-bit words held in one word memory, cleared at reset by per-word
// valid bits, so items are taken right after reset with no clearing pass.
// Items are handled one at a time. Bit and run actions visit only the words
// they touch, count visits every word of the map, find first, find next and
// find last stop at the first word holding a hit, and clear all, zero-length
// runs and unused actions visit no word. Words are read through the single
// read port of the word memory, one word per cycle, with the modified word
// written back on the other port. A finished result waits in the output
// register while the next item is already accepted.
module bitmap_set_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bss_pkg::ACT_W-1:0]   in_action,
  input  logic [bss_pkg::POS_W-1:0]   in_index,
  input  logic [bss_pkg::LEN_W-1:0]   in_run_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [bss_pkg::POS_W-1:0]   out_position,
  output logic [bss_pkg::CNT_W-1:0]   out_count,
  output logic                        out_clipped
);

  bss_pkg::req_t  req;
  bss_pkg::stat_t stat;
  bss_pkg::res_t  out_res_r;
  logic           out_valid_r;
  logic           res_take;

  assign in_stall       = !stat.idle;
  assign req.valid      = in_valid;
  assign req.action     = in_action;
  assign req.index      = in_index;
  assign req.run_length = in_run_length;

  assign res_take = !out_valid_r || !out_stall;

  bss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .res_take (res_take),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= stat.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && stat.res_valid) begin
      out_res_r <= stat.res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_res_r.found;
  assign out_position = out_res_r.position;
  assign out_count    = out_res_r.count;
  assign out_clipped  = out_res_r.clipped;

endmodule
